// ----- hw/rtl/uer_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  // Field widths.
  localparam int unsigned CaptureWidth = 16;
  localparam int unsigned TickWidth    = 32;
  localparam int unsigned DistWidth    = 10;
  localparam int unsigned ModWidth     = 16;
  localparam int unsigned DivWidth     = 16;
  localparam int unsigned CountWidth   = 4;
  localparam int unsigned PhaseWidth   = 2;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;

  // Queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Phase codes as they show on the result beat.
  localparam logic [PhaseWidth-1:0] PhaseTrig = 2'd0;
  localparam logic [PhaseWidth-1:0] PhaseWait = 2'd1;
  localparam logic [PhaseWidth-1:0] PhaseProc = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgTimerModulo   = 3'd0,
    CfgUnitDivisor   = 3'd1,
    CfgMaxDistance   = 3'd2,
    CfgAcceptDelta   = 3'd3,
    CfgOverflowLimit = 3'd4
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [ModWidth-1:0]   TimerModuloRst   = 16'd65535;
  localparam logic [DivWidth-1:0]   UnitDivisorRst   = 16'd134;
  localparam logic [DistWidth-1:0]  MaxDistanceRst   = 10'd150;
  localparam logic [DistWidth-1:0]  AcceptDeltaRst   = 10'd20;
  localparam logic [CountWidth-1:0] OverflowLimitRst = 4'd4;

  // One timer event.
  typedef struct packed {
    logic                    compare_event;
    logic                    overflow_event;
    logic                    trailing_edge_event;
    logic [CaptureWidth-1:0] lead_capture;
    logic [CaptureWidth-1:0] trail_capture;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic                  trigger_level;
    logic [PhaseWidth-1:0] phase;
    logic                  sample_done;
    logic [DistWidth-1:0]  raw_distance;
    logic [DistWidth-1:0]  filtered_distance;
  } out_item_t;

  // Classified event as it travels from the front to the back.
  typedef struct packed {
    logic                  trigger_level;
    logic [PhaseWidth-1:0] phase;
    logic                  sample_done;
    logic [TickWidth-1:0]  echo_ticks;
  } job_t;

endpackage

`default_nettype wire

// ----- hw/rtl/uer_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uer_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  uer_pkg::in_item_t                  in_data_i,
  input  wire  [uer_pkg::ModWidth-1:0]       timer_modulo_i,
  input  wire  [uer_pkg::CountWidth-1:0]     overflow_limit_i,
  input  wire                                queue_full_i,
  output logic                               push_o,
  output uer_pkg::job_t                      job_o
);
  import uer_pkg::*;

  typedef enum logic [PhaseWidth-1:0] {
    PhTrig = 2'd0,
    PhWait = 2'd1,
    PhProc = 2'd2
  } phase_e;

  phase_e                 phase_q, phase_d, phase_ev;
  logic [CountWidth-1:0]  ovf_cnt_q, ovf_cnt_d, ovf_cnt_ev;
  logic                   trig_q, trig_d;
  logic                   done;
  logic                   accept;
  logic [TickWidth-1:0]   diff;
  logic [ModWidth+CountWidth:0] span;
  logic [TickWidth-1:0]   ticks;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept;

  // Walk the three flags in order: compare, overflow, trailing edge.
  always_comb begin
    trig_d     = trig_q;
    phase_ev   = phase_q;
    ovf_cnt_ev = ovf_cnt_q;
    if (in_data_i.compare_event && phase_q == PhTrig) begin
      trig_d = 1'b1;
    end
    if (in_data_i.overflow_event) begin
      if (phase_q == PhTrig) begin
        trig_d   = 1'b0;
        phase_ev = PhWait;
      end else if (phase_q == PhWait) begin
        if (ovf_cnt_q < overflow_limit_i) begin
          ovf_cnt_ev = ovf_cnt_q + 1'b1;
        end else begin
          phase_ev = PhProc;
        end
      end
    end
    if (in_data_i.trailing_edge_event && phase_ev == PhWait) begin
      phase_ev = PhProc;
    end
    done = (phase_ev == PhProc);
    // A finished measurement goes back to the trigger phase at once.
    phase_d   = done ? PhTrig : phase_ev;
    ovf_cnt_d = done ? '0 : ovf_cnt_ev;
  end

  // Echo length in ticks, modulo 2^32.
  always_comb begin
    diff  = {{(TickWidth-CaptureWidth){1'b0}}, in_data_i.trail_capture}
          - {{(TickWidth-CaptureWidth){1'b0}}, in_data_i.lead_capture};
    span  = ovf_cnt_ev * ({1'b0, timer_modulo_i} + 17'd1);
    ticks = diff + {{(TickWidth-ModWidth-CountWidth-1){1'b0}}, span};
  end

  always_comb begin
    job_o.trigger_level = trig_d;
    job_o.phase         = phase_d;
    job_o.sample_done   = done;
    job_o.echo_ticks    = ticks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhTrig;
      ovf_cnt_q <= '0;
      trig_q    <= 1'b0;
    end else if (accept) begin
      phase_q   <= phase_d;
      ovf_cnt_q <= ovf_cnt_d;
      trig_q    <= trig_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uer_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uer_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  uer_pkg::job_t  push_data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           empty_o,
  output uer_pkg::job_t  head_o
);
  import uer_pkg::*;

  job_t                  slot_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]  level_q;

  assign full_o  = (level_q == QueueCntW'(QueueDepth));
  assign empty_o = (level_q == '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Entry storage; the front only pushes when there is room.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/uer_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uer_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              empty_i,
  input  uer_pkg::job_t                    head_i,
  output logic                             pop_o,
  input  wire  [uer_pkg::DivWidth-1:0]     unit_divisor_i,
  input  wire  [uer_pkg::DistWidth-1:0]    max_distance_i,
  input  wire  [uer_pkg::DistWidth-1:0]    accept_delta_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output uer_pkg::out_item_t               out_data_o
);
  import uer_pkg::*;

  localparam int unsigned StepW = $clog2(TickWidth);

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkDone
  } back_state_e;

  back_state_e            state_q;
  logic [TickWidth-1:0]   quo_q;
  logic [DivWidth-1:0]    rem_q;
  logic [StepW-1:0]       step_q;
  logic                   pend_trig_q;
  logic [PhaseWidth-1:0]  pend_phase_q;
  logic [DistWidth-1:0]   newest_q, middle_q, dist_q;
  logic                   out_vld_q;
  out_item_t              out_q;

  logic [DivWidth:0]      rem_sh, rem_sub;
  logic                   rem_ge;
  logic [DistWidth-1:0]   q_sat, filt;
  logic [DistWidth:0]     band_hi, mid_lo;
  logic                   reject;
  logic                   out_free;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_vld_q || out_ready_i;
  assign pop_o       = (state_q == BkIdle) && !empty_i && out_free;

  // One restoring division step. A zero divisor always subtracts,
  // which yields an all-ones quotient.
  always_comb begin
    rem_sh  = {rem_q, quo_q[TickWidth-1]};
    rem_ge  = (rem_sh >= {1'b0, unit_divisor_i});
    rem_sub = rem_sh - {1'b0, unit_divisor_i};
  end

  // Saturate the quotient and run the outlier filter on the shifted history:
  // the new middle is the old newest, the new oldest is the old middle.
  always_comb begin
    q_sat   = (quo_q > {{(TickWidth-DistWidth){1'b0}}, max_distance_i})
            ? max_distance_i : quo_q[DistWidth-1:0];
    band_hi = {1'b0, middle_q} + {1'b0, accept_delta_i};
    mid_lo  = {1'b0, newest_q} + {1'b0, accept_delta_i};
    reject  = ({1'b0, newest_q} > band_hi) || (mid_lo < {1'b0, middle_q});
    filt    = reject ? q_sat : newest_q;
  end

  // Back sequencer with the sample history and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BkIdle;
      quo_q        <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      pend_trig_q  <= 1'b0;
      pend_phase_q <= PhaseTrig;
      newest_q     <= '0;
      middle_q     <= '0;
      dist_q       <= '0;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
    end else begin
      unique case (state_q)
        BkIdle: begin
          if (out_vld_q && out_ready_i) begin
            out_vld_q <= 1'b0;
          end
          if (pop_o) begin
            if (head_i.sample_done) begin
              quo_q        <= head_i.echo_ticks;
              rem_q        <= '0;
              step_q       <= '0;
              pend_trig_q  <= head_i.trigger_level;
              pend_phase_q <= head_i.phase;
              state_q      <= BkDiv;
            end else begin
              out_q.trigger_level     <= head_i.trigger_level;
              out_q.phase             <= head_i.phase;
              out_q.sample_done       <= 1'b0;
              out_q.raw_distance      <= newest_q;
              out_q.filtered_distance <= dist_q;
              out_vld_q               <= 1'b1;
            end
          end
        end
        BkDiv: begin
          quo_q  <= {quo_q[TickWidth-2:0], rem_ge};
          rem_q  <= rem_ge ? rem_sub[DivWidth-1:0] : rem_sh[DivWidth-1:0];
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(TickWidth - 1)) begin
            state_q <= BkDone;
          end
        end
        BkDone: begin
          // The output register was freed when this job left the queue.
          newest_q                <= q_sat;
          middle_q                <= newest_q;
          dist_q                  <= filt;
          out_q.trigger_level     <= pend_trig_q;
          out_q.phase             <= pend_phase_q;
          out_q.sample_done       <= 1'b1;
          out_q.raw_distance      <= q_sat;
          out_q.filtered_distance <= filt;
          out_vld_q               <= 1'b1;
          state_q                 <= BkIdle;
        end
        default: begin
          state_q <= BkIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ultrasonic_echo_ranger_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Beat
// in        input      in_valid_i / in_ready_o    uer_pkg::in_item_t, one timer event
// out       output     out_valid_o / out_ready_i  uer_pkg::out_item_t, one result
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An event without a finished measurement passes through the job queue to the output register.
// An event that finishes a measurement also runs the 32-step serial divider before its result.
// The front takes events while the two-entry job queue has room, so it runs ahead of the back.
// Output register holds a result until taken; a stall there stalls the back, then the front.
// Reset is asynchronous and active low; there is no clearing pass after it.

module ultrasonic_echo_ranger_top (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  uer_pkg::in_item_t                     in_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output uer_pkg::out_item_t                    out_data_o,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [uer_pkg::CfgIdxWidth-1:0]       cfg_index_i,
  input  wire  [uer_pkg::CfgDataWidth-1:0]      cfg_data_i
);
  import uer_pkg::*;

  logic [ModWidth-1:0]   timer_modulo_q;
  logic [DivWidth-1:0]   unit_divisor_q;
  logic [DistWidth-1:0]  max_distance_q;
  logic [DistWidth-1:0]  accept_delta_q;
  logic [CountWidth-1:0] overflow_limit_q;

  logic  push;
  logic  pop;
  logic  queue_full;
  logic  queue_empty;
  job_t  push_job;
  job_t  head_job;

  // Configuration registers; indexes past the list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_modulo_q   <= TimerModuloRst;
      unit_divisor_q   <= UnitDivisorRst;
      max_distance_q   <= MaxDistanceRst;
      accept_delta_q   <= AcceptDeltaRst;
      overflow_limit_q <= OverflowLimitRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgTimerModulo:   timer_modulo_q   <= cfg_data_i[ModWidth-1:0];
        CfgUnitDivisor:   unit_divisor_q   <= cfg_data_i[DivWidth-1:0];
        CfgMaxDistance:   max_distance_q   <= cfg_data_i[DistWidth-1:0];
        CfgAcceptDelta:   accept_delta_q   <= cfg_data_i[DistWidth-1:0];
        CfgOverflowLimit: overflow_limit_q <= cfg_data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  uer_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_data_i        (in_data_i),
    .timer_modulo_i   (timer_modulo_q),
    .overflow_limit_i (overflow_limit_q),
    .queue_full_i     (queue_full),
    .push_o           (push),
    .job_o            (push_job)
  );

  uer_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .head_o      (head_job)
  );

  uer_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (queue_empty),
    .head_i         (head_job),
    .pop_o          (pop),
    .unit_divisor_i (unit_divisor_q),
    .max_distance_i (max_distance_q),
    .accept_delta_i (accept_delta_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o)
  );

  // A completed sample always leaves the ranger back in the trigger phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sample_done |-> out_data_o.phase == PhaseTrig)
    else $error("sample completed outside the trigger phase");

  // The trigger pin is only ever high while in the trigger phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger_level |-> out_data_o.phase == PhaseTrig)
    else $error("trigger pin high after leaving the trigger phase");

  // Processing is never visible as a resting phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.phase != PhaseProc)
    else $error("result reports the processing phase");

  // The front stalls only when the job queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> queue_full && !queue_empty)
    else $error("input stalled with room in the job queue");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import uer_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int ResetCycles   = 5;
  localparam int SettleCycles  = 40;
  localparam int CycleLimit    = 400000;
  localparam int NumSettings   = 8;
  localparam int EventsPerSet  = 216;
  localparam int HoldOffAt     = 900;
  localparam int HoldOffCycles = 400;
  localparam int NumDirected   = 24;

  // One row of the directed sequence; the typed result is used where has_typed is set.
  typedef struct packed {
    logic      has_typed;
    in_item_t  ev;
    out_item_t typed;
  } step_row_t;

  localparam step_row_t DirectedRows [NumDirected] = '{
    // Idle event right after reset.
    '{1'b1, '{1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000}, '{1'b0, PhaseTrig, 1'b0, 10'd0, 10'd0}},
    // Compare raises the trigger pin.
    '{1'b1, '{1'b1, 1'b0, 1'b0, 16'hffff, 16'hffff}, '{1'b1, PhaseTrig, 1'b0, 10'd0, 10'd0}},
    // A trailing edge in the trigger phase is ignored.
    '{1'b1, '{1'b0, 1'b0, 1'b1, 16'hffff, 16'h0000}, '{1'b1, PhaseTrig, 1'b0, 10'd0, 10'd0}},
    // Overflow drops the pin and starts the wait.
    '{1'b1, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '{1'b0, PhaseWait, 1'b0, 10'd0, 10'd0}},
    // A compare while waiting is ignored.
    '{1'b1, '{1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000}, '{1'b0, PhaseWait, 1'b0, 10'd0, 10'd0}},
    // Full-scale echo saturates at the maximum.
    '{1'b1, '{1'b0, 1'b0, 1'b1, 16'h0000, 16'hffff}, '{1'b0, PhaseTrig, 1'b1, 10'd150, 10'd0}},
    '{1'b0, '{1'b1, 1'b0, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b0, 1'b1, 16'd100, 16'd770}, '0},
    // Compare and overflow together, then overflows up to the limit and a time-out.
    '{1'b0, '{1'b1, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h1234, 16'h0034}, '0},
    // All three flags at once complete a measurement in one event.
    '{1'b0, '{1'b1, 1'b1, 1'b1, 16'h0000, 16'd2680}, '0},
    // Overflow and trailing edge together while waiting.
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b1, 16'd5000, 16'd5000}, '0},
    // Lead capture above the trail capture wraps the difference.
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b0, 1'b1, 16'hffff, 16'h0000}, '0},
    // A few steady samples to settle the outlier filter.
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b0, 1'b1, 16'h0000, 16'd2700}, '0},
    '{1'b0, '{1'b0, 1'b1, 1'b0, 16'h0000, 16'h0000}, '0},
    '{1'b0, '{1'b0, 1'b0, 1'b1, 16'h0000, 16'd2800}, '0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  out_item_t               out_data;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  // Ranger state as the testbench tracks it.
  logic [ModWidth-1:0]   reg_modulo;
  logic [DivWidth-1:0]   reg_divisor;
  logic [DistWidth-1:0]  reg_max_range;
  logic [DistWidth-1:0]  reg_delta;
  logic [CountWidth-1:0] reg_ovf_limit;
  logic [PhaseWidth-1:0] echo_phase;
  logic [CountWidth-1:0] echo_overflows;
  logic                  pin_level;
  logic [DistWidth-1:0]  hist_newest;
  logic [DistWidth-1:0]  hist_middle;
  logic [DistWidth-1:0]  hist_oldest;
  logic [DistWidth-1:0]  held_range;

  out_item_t pending_readings [$];
  int        error_count   = 0;
  int        results_seen  = 0;
  int        samples_seen  = 0;
  int        events_sent   = 0;
  int        stall_cycles  = 0;
  int        cycle_count   = 0;
  bit        no_idle       = 1'b0;
  bit        held_off      = 1'b0;

  ultrasonic_echo_ranger_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Apply one timer event to the tracked state and return the reading it yields.
  function automatic out_item_t track_echo_event(input in_item_t ev);
    logic [TickWidth-1:0] echo_ticks;
    logic [TickWidth-1:0] quotient;
    int                   mid;
    int                   old;
    int                   delta;
    out_item_t            reading;
    logic                 done;
    done = 1'b0;
    if (ev.compare_event && echo_phase == PhaseTrig) begin
      pin_level = 1'b1;
    end
    if (ev.overflow_event) begin
      if (echo_phase == PhaseTrig) begin
        pin_level  = 1'b0;
        echo_phase = PhaseWait;
      end else if (echo_phase == PhaseWait) begin
        if (echo_overflows < reg_ovf_limit) begin
          echo_overflows = echo_overflows + 1'b1;
        end else begin
          echo_phase = PhaseProc;
        end
      end
    end
    if (ev.trailing_edge_event && echo_phase == PhaseWait) begin
      echo_phase = PhaseProc;
    end
    // Finish the measurement: ticks, division, saturation and the outlier filter.
    if (echo_phase == PhaseProc) begin
      echo_ticks = TickWidth'(ev.trail_capture) - TickWidth'(ev.lead_capture)
                 + TickWidth'(echo_overflows) * (TickWidth'(reg_modulo) + 32'd1);
      quotient = (reg_divisor == '0) ? '1 : echo_ticks / TickWidth'(reg_divisor);
      if (quotient > TickWidth'(reg_max_range)) begin
        quotient = TickWidth'(reg_max_range);
      end
      hist_oldest = hist_middle;
      hist_middle = hist_newest;
      hist_newest = quotient[DistWidth-1:0];
      mid   = hist_middle;
      old   = hist_oldest;
      delta = reg_delta;
      if (mid > old + delta || mid < old - delta) begin
        held_range = hist_newest;
      end else begin
        held_range = hist_middle;
      end
      echo_phase     = PhaseTrig;
      echo_overflows = '0;
      done           = 1'b1;
    end
    reading.trigger_level     = pin_level;
    reading.phase             = echo_phase;
    reading.sample_done       = done;
    reading.raw_distance      = hist_newest;
    reading.filtered_distance = held_range;
    return reading;
  endfunction

  // Offer one event beat and log its reading once it is taken.
  task automatic send_event(input in_item_t ev, input logic use_typed, input out_item_t typed);
    out_item_t reading;
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk_i); while (!in_ready);
    reading = track_echo_event(ev);
    if (use_typed) begin
      reading = typed;
    end
    pending_readings.push_back(reading);
    events_sent++;
  endtask

  // Write one register beat; the valid stays high for a following write.
  task automatic write_reg(input logic [CfgIdxWidth-1:0] index,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (index)
      CfgTimerModulo:   reg_modulo    = data;
      CfgUnitDivisor:   reg_divisor   = data;
      CfgMaxDistance:   reg_max_range = data[DistWidth-1:0];
      CfgAcceptDelta:   reg_delta     = data[DistWidth-1:0];
      CfgOverflowLimit: reg_ovf_limit = data[CountWidth-1:0];
      default: ;
    endcase
  endtask

  // Wait until every reading is back and the block has drained.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Compare each reading beat with the oldest expected one.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        error_count++;
        $display("%0t: unexpected reading, expected none, actual %h", $time, out_data);
      end else begin
        want = pending_readings.pop_front();
        check_field("trigger_level", want.trigger_level, out_data.trigger_level);
        check_field("phase", want.phase, out_data.phase);
        check_field("sample_done", want.sample_done, out_data.sample_done);
        check_field("raw_distance", want.raw_distance, out_data.raw_distance);
        check_field("filtered_distance", want.filtered_distance, out_data.filtered_distance);
      end
      if (out_data.sample_done) begin
        samples_seen++;
      end
      results_seen++;
    end
  end

  // Count input backpressure and guard against a hung run.
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_ready) begin
      stall_cycles++;
    end
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d readings pending",
               $time, cycle_count, pending_readings.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Reading side: random stalls, one long hold-off, and a quiet stretch.
  initial begin : reading_side
    out_ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_n) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held_off && results_seen >= HoldOffAt) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_ready <= no_idle || ($urandom_range(99) >= 16);
    end
  end

  // Event side: reset, directed rows, then random events under several settings.
  initial begin : stimulus
    int                    row;
    int                    setting;
    int                    k;
    int unsigned           pick;
    logic [TickWidth-1:0]  span;
    logic [ModWidth-1:0]   new_modulo;
    logic [DivWidth-1:0]   new_divisor;
    logic [DistWidth-1:0]  new_max;
    logic [DistWidth-1:0]  new_delta;
    logic [CountWidth-1:0] new_limit;
    logic [CfgIdxWidth-1:0] spare_index;
    in_item_t              ev;

    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;

    reg_modulo     = TimerModuloRst;
    reg_divisor    = UnitDivisorRst;
    reg_max_range  = MaxDistanceRst;
    reg_delta      = AcceptDeltaRst;
    reg_ovf_limit  = OverflowLimitRst;
    echo_phase     = PhaseTrig;
    echo_overflows = '0;
    pin_level      = 1'b0;
    hist_newest    = '0;
    hist_middle    = '0;
    hist_oldest    = '0;
    held_range     = '0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < NumDirected; row++) begin
      send_event(DirectedRows[row].ev, DirectedRows[row].has_typed, DirectedRows[row].typed);
    end

    for (setting = 0; setting < NumSettings; setting++) begin
      settle();
      // The first three settings take the register extremes, the rest are random.
      case (setting)
        0: begin
          new_modulo = 16'hffff; new_divisor = 16'd1; new_max = 10'd1023;
          new_delta = 10'd0; new_limit = 4'd0;
        end
        1: begin
          new_modulo = 16'h0000; new_divisor = 16'hffff; new_max = 10'd0;
          new_delta = 10'd1023; new_limit = 4'd15;
        end
        2: begin
          new_modulo = 16'h0000; new_divisor = 16'd0; new_max = 10'd1023;
          new_delta = 10'd1023; new_limit = 4'd15;
        end
        default: begin
          new_modulo  = 16'($urandom);
          new_divisor = 16'($urandom_range(300, 1));
          new_max     = 10'($urandom_range(1023));
          new_delta   = 10'($urandom_range(120));
          new_limit   = 4'($urandom_range(6));
        end
      endcase
      write_reg(CfgTimerModulo, new_modulo);
      write_reg(CfgUnitDivisor, new_divisor);
      write_reg(CfgMaxDistance, {6'($urandom), new_max});
      write_reg(CfgAcceptDelta, {6'($urandom), new_delta});
      write_reg(CfgOverflowLimit, {12'($urandom), new_limit});
      // An index past the last register must change nothing.
      spare_index = CfgOverflowLimit + 3'($urandom_range(3, 1));
      write_reg(spare_index, 16'($urandom));
      cfg_valid <= 1'b0;
      @(posedge clk_i);

      for (k = 0; k < EventsPerSet; k++) begin
        no_idle = (setting == 4 && k < 160);
        pick = $urandom_range(99);
        ev = '0;
        ev.lead_capture = 16'($urandom);
        span = TickWidth'(reg_divisor)
             * $urandom_range(int'(reg_max_range) + int'(reg_max_range) / 4 + 2)
             + $urandom_range(reg_divisor);
        ev.trail_capture = ev.lead_capture + span[CaptureWidth-1:0];
        if (pick < 12) begin
          // Noise: any flags with any captures.
          ev = {3'($urandom), 16'($urandom), 16'($urandom)};
        end else if (echo_phase == PhaseTrig) begin
          if (!pin_level && pick < 60) begin
            ev.compare_event = 1'b1;
          end else begin
            ev.overflow_event = 1'b1;
            ev.compare_event  = (pick % 7 == 0);
          end
        end else begin
          if (pick < 45) begin
            ev.overflow_event = 1'b1;
          end else begin
            ev.trailing_edge_event = 1'b1;
          end
          if (pick % 9 == 0) begin
            ev.overflow_event      = 1'b1;
            ev.trailing_edge_event = 1'b1;
          end
          ev.compare_event = (pick % 5 == 0);
        end
        send_event(ev, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    settle();
    $display("tb_top: %0d events over %0d register settings, %0d ranging samples completed",
             events_sent, NumSettings + 1, samples_seen);
    $display("tb_top: %0d cycles of input backpressure, %0d mismatches",
             stall_cycles, error_count);
    if (error_count == 0 && pending_readings.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
